/* rtl/core/jpp_pkg.sv */
`timescale 1ns / 1ps

package jpp_pkg;

  localparam int DEPTH_W = 5;
  localparam int CNT_W   = DEPTH_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_JSON   = 3'd1,
    ST_UNMATCHED  = 3'd2,
    ST_OPEN_STR   = 3'd3,
    ST_OPEN_CONT  = 3'd4,
    ST_TOO_DEEP   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_LINE  = 2'd1,
    HELD_SPACE = 2'd2
  } held_t;

  // Emission order of one command; a phase is skipped when its part is absent.
  typedef enum logic [3:0] {
    PH_PRE_SP   = 4'd0,
    PH_PRE_NL   = 4'd1,
    PH_PRE_IND  = 4'd2,
    PH_MID_NL   = 4'd3,
    PH_MID_IND  = 4'd4,
    PH_CHAR     = 4'd5,
    PH_POST_NL  = 4'd6,
    PH_POST_IND = 4'd7,
    PH_FIN_SP   = 4'd8,
    PH_FIN_NL   = 4'd9,
    PH_STATUS   = 4'd10,
    PH_DONE     = 4'd11
  } phase_t;

  localparam int PH_NUM = 11;

  typedef struct packed {
    held_t               pre;
    logic                mid;
    logic                ch_en;
    logic [7:0]          ch;
    logic                post;
    logic [DEPTH_W-1:0]  ind;
    held_t               fin;
    logic                st_en;
    status_t             status;
  } cmd_t;

endpackage

/* rtl/core/json_pretty_printer_top.sv */
// Channel | Signals                               | Direction
// in      | in_valid, in_stall, in_byte, in_last  | text bytes in
// out     | out_valid, out_stall, out_byte,       | formatted bytes and the
//         |   byte_valid, out_last, status        |   closing status item out
//
// The back end emits the results of one command in turn and holds it until all
// are out, so plain text runs at one byte per cycle while out_stall is low.
// A four-entry command queue parts the classifier from the emitter; in_stall is
// high while it is full. A byte passes a queue entry, the command register and the
// output register, which out_stall holds. Reset is synchronous and active high.
`timescale 1ns / 1ps

module json_pretty_printer_top
  import jpp_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last,
  output logic [2:0] status
);

  logic q_full, q_not_empty, q_push, q_pop;
  cmd_t push_cmd, head_cmd;

  jpp_front #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  jpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .head      (head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  jpp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_cmd),
    .q_not_empty (q_not_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .out_last    (out_last),
    .status      (status)
  );

`ifndef SYNTHESIS
  a_status_item_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_last && (out_byte == CH_NUL))
    else $error("status item carries a byte");

  a_char_item_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> !out_last && (status == ST_OK))
    else $error("character item carries status or end mark");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("command queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue pushed while full");
`endif

endmodule

/* rtl/core/jpp_front.sv */
`timescale 1ns / 1ps

module jpp_front
  import jpp_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_stall,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  logic [DEPTH_W-1:0] depth, depth_next;
  logic               in_str, in_str_next;
  logic               esc, esc_next;
  logic               empty, empty_next;
  held_t              held, held_next;
  logic               start, start_next;
  status_t            err, err_next;

  logic accept;
  logic is_ws, is_open, is_close;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_ws    = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                    (in_byte == CH_CR) || (in_byte == CH_NL);
  assign is_open  = (in_byte == CH_LBRACE) || (in_byte == CH_LBRACK);
  assign is_close = (in_byte == CH_RBRACE) || (in_byte == CH_RBRACK);

  always_comb begin
    depth_next  = depth;
    in_str_next = in_str;
    esc_next    = esc;
    empty_next  = empty;
    held_next   = held;
    start_next  = start;
    err_next    = err;
    cmd         = '0;
    cmd.pre     = HELD_NONE;
    cmd.fin     = HELD_NONE;
    cmd.status  = ST_OK;
    cmd.ch      = in_byte;
    cmd.ind     = depth;

    if (err == ST_OK) begin
      if (in_str) begin
        cmd.ch_en = 1'b1;
        if (esc) begin
          esc_next = 1'b0;
        end else if (in_byte == CH_BSLASH) begin
          esc_next = 1'b1;
        end else if (in_byte == CH_QUOTE) begin
          in_str_next = 1'b0;
        end
      end else if (is_ws) begin
        // drop
      end else if (!start && !is_open) begin
        err_next = ST_NOT_JSON;
      end else begin
        start_next = 1'b1;
        if (is_open) begin
          if (depth >= DEPTH_W'(MAX_DEPTH)) begin
            err_next = ST_TOO_DEEP;
          end else begin
            cmd.pre    = held;
            cmd.ch_en  = 1'b1;
            depth_next = depth + 1'b1;
            held_next  = HELD_LINE;
            empty_next = 1'b1;
          end
        end else if (is_close) begin
          if (depth == '0) begin
            err_next = ST_UNMATCHED;
          end else begin
            depth_next = depth - 1'b1;
            cmd.ind    = depth - 1'b1;
            if (!empty) begin
              cmd.pre = held;
              cmd.mid = 1'b1;
            end
            held_next  = HELD_NONE;
            cmd.ch_en  = 1'b1;
            empty_next = 1'b0;
          end
        end else if (in_byte == CH_COMMA) begin
          held_next  = HELD_NONE;
          cmd.ch_en  = 1'b1;
          cmd.post   = 1'b1;
          empty_next = 1'b0;
        end else if (in_byte == CH_COLON) begin
          cmd.ch_en = 1'b1;
          held_next = HELD_SPACE;
        end else begin
          cmd.pre    = held;
          held_next  = HELD_NONE;
          cmd.ch_en  = 1'b1;
          empty_next = 1'b0;
          if (in_byte == CH_QUOTE) begin
            in_str_next = 1'b1;
          end
        end
      end
    end

    if (in_last) begin
      if (err_next == ST_OK) begin
        if (!start_next) begin
          err_next = ST_NOT_JSON;
        end else if (in_str_next) begin
          err_next = ST_OPEN_STR;
        end else if (depth_next != '0) begin
          err_next = ST_OPEN_CONT;
        end else begin
          cmd.fin = held_next;
        end
      end
      cmd.st_en  = 1'b1;
      cmd.status = err_next;
      // back to the reset state for the next text
      depth_next  = '0;
      in_str_next = 1'b0;
      esc_next    = 1'b0;
      empty_next  = 1'b0;
      held_next   = HELD_NONE;
      start_next  = 1'b0;
      err_next    = ST_OK;
    end

    push = accept && (cmd.ch_en || cmd.st_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= '0;
      in_str <= 1'b0;
      esc    <= 1'b0;
      empty  <= 1'b0;
      held   <= HELD_NONE;
      start  <= 1'b0;
      err    <= ST_OK;
    end else if (accept) begin
      depth  <= depth_next;
      in_str <= in_str_next;
      esc    <= esc_next;
      empty  <= empty_next;
      held   <= held_next;
      start  <= start_next;
      err    <= err_next;
    end
  end

endmodule

/* rtl/core/jpp_queue.sv */
`timescale 1ns / 1ps

module jpp_queue
  import jpp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic not_empty,
  output logic full
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/jpp_back.sv */
`timescale 1ns / 1ps

module jpp_back
  import jpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_not_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last,
  output logic [2:0] status
);

  phase_t           phase, phase_next;
  cmd_t             cur, cur_next;
  logic             cur_valid, cur_valid_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic       out_free, emit, is_ind, more_ind, finish, load;
  phase_t     adv;
  logic [7:0] ob;
  logic       obv, ol;
  status_t    ost;

  function automatic phase_t first_from(cmd_t c, logic [3:0] from);
    logic [PH_NUM-1:0] en;
    phase_t            res;
    en = '0;
    res = PH_DONE;
    en[PH_PRE_SP]   = (c.pre == HELD_SPACE);
    en[PH_PRE_NL]   = (c.pre == HELD_LINE);
    en[PH_PRE_IND]  = (c.pre == HELD_LINE) && (c.ind != '0);
    en[PH_MID_NL]   = c.mid;
    en[PH_MID_IND]  = c.mid && (c.ind != '0);
    en[PH_CHAR]     = c.ch_en;
    en[PH_POST_NL]  = c.post;
    en[PH_POST_IND] = c.post && (c.ind != '0);
    en[PH_FIN_SP]   = (c.fin == HELD_SPACE);
    en[PH_FIN_NL]   = (c.fin == HELD_LINE);
    en[PH_STATUS]   = c.st_en;
    for (int i = PH_NUM - 1; i >= 0; i--) begin
      if (en[i] && (i >= int'(from))) begin
        res = phase_t'(4'(i));
      end
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] ind_count(cmd_t c);
    return {c.ind, 1'b0} - 1'b1;
  endfunction

  always_comb begin
    ob  = CH_SPACE;
    obv = 1'b1;
    ol  = 1'b0;
    ost = ST_OK;
    unique case (phase) inside
      PH_PRE_NL, PH_MID_NL, PH_POST_NL, PH_FIN_NL: ob = CH_NL;
      PH_CHAR: ob = cur.ch;
      PH_STATUS: begin
        ob  = CH_NUL;
        obv = 1'b0;
        ol  = 1'b1;
        ost = cur.status;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_free = !out_valid || !out_stall;
    emit     = cur_valid && out_free;
    is_ind   = (phase == PH_PRE_IND) || (phase == PH_MID_IND) ||
               (phase == PH_POST_IND);
    more_ind = is_ind && (cnt != '0);
    adv      = first_from(cur, 4'(phase) + 4'd1);
    finish   = emit && !more_ind && (adv == PH_DONE);
    load     = (!cur_valid || finish) && q_not_empty;
    pop      = load;

    phase_next     = phase;
    cur_next       = cur;
    cur_valid_next = cur_valid;
    cnt_next       = cnt;

    if (emit) begin
      if (more_ind) begin
        cnt_next = cnt - 1'b1;
      end else if (adv != PH_DONE) begin
        phase_next = adv;
        cnt_next   = ind_count(cur);
      end
    end
    if (finish) begin
      cur_valid_next = 1'b0;
      phase_next     = PH_DONE;
    end
    if (load) begin
      cur_next       = head;
      cur_valid_next = 1'b1;
      phase_next     = first_from(head, 4'd0);
      cnt_next       = ind_count(head);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      cur_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      cur_valid <= cur_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    cnt <= cnt_next;
  end

  // output register: load whenever the downstream slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_byte   <= ob;
      byte_valid <= obv;
      out_last   <= ol;
      status     <= ost;
    end
  end

endmodule

/* bench/json_pretty_printer_top_tb.sv */
`timescale 1ns / 1ps

module json_pretty_printer_top_tb;
  import jpp_pkg::*;

  localparam int DEPTH_LIM = 16;
  localparam int LONG_HOLD = 300;
  localparam int RAND_ITEMS = 290;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [7:0] ch;
    logic       bv;
    logic       last;
    logic [2:0] st;
  } res_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    int         rep;
    logic       typed;
    status_t    st;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic [2:0] status;

  json_pretty_printer_top #(.MAX_DEPTH(DEPTH_LIM)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .byte_valid(byte_valid), .out_last(out_last), .status(status)
  );

  always #5 clk = ~clk;

  // formatter state mirrored by the bench
  logic [4:0] fmt_depth = '0;
  logic       fmt_in_str = 1'b0;
  logic       fmt_esc = 1'b0;
  logic       fmt_empty = 1'b0;
  held_t      fmt_held = HELD_NONE;
  logic       fmt_started = 1'b0;
  status_t    fmt_err = ST_OK;

  // status typed into the table for the row being sent
  logic       typed_en = 1'b0;
  status_t    typed_st = ST_OK;

  res_t       pending_out[$];
  logic [7:0] text_q[$];
  row_t       stim_rows[$];

  int   fail_cnt = 0;
  int   items_sent = 0;
  int   rand_items = 0;
  int   results_seen = 0;
  int   texts_done = 0;
  int   deepest = 0;
  int   burst_left = 0;
  int   cycles = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   seg_left = 0;
  int   seg_mode = 0;
  bit   chain_mode = 0;
  logic [7:0] status_seen = '0;
  res_t got;
  res_t want;

  task automatic put_text(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  task automatic push_char(input logic [7:0] c);
    res_t r;
    r = '{ch: c, bv: 1'b1, last: 1'b0, st: ST_OK};
    pending_out.insert(pending_out.size(), r);
  endtask

  task automatic push_line();
    int i;
    push_char(CH_NL);
    for (i = 0; i < 2 * fmt_depth; i++) push_char(CH_SPACE);
  endtask

  task automatic flush_held();
    if (fmt_held == HELD_LINE) push_line();
    else if (fmt_held == HELD_SPACE) push_char(CH_SPACE);
    fmt_held = HELD_NONE;
  endtask

  task automatic fmt_reset();
    fmt_depth = '0;
    fmt_in_str = 1'b0;
    fmt_esc = 1'b0;
    fmt_empty = 1'b0;
    fmt_held = HELD_NONE;
    fmt_started = 1'b0;
    fmt_err = ST_OK;
  endtask

  // Work out the formatted items caused by one accepted input byte.
  task automatic format_byte(input logic [7:0] b, input logic l);
    res_t stat_item;
    if (fmt_err == ST_OK) begin
      if (fmt_in_str) begin
        push_char(b);
        if (fmt_esc) fmt_esc = 1'b0;
        else if (b == CH_BSLASH) fmt_esc = 1'b1;
        else if (b == CH_QUOTE) fmt_in_str = 1'b0;
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_NL) begin
        // drop
      end else if (!fmt_started && b != CH_LBRACE && b != CH_LBRACK) begin
        fmt_err = ST_NOT_JSON;
      end else begin
        fmt_started = 1'b1;
        if (b == CH_LBRACE || b == CH_LBRACK) begin
          if (fmt_depth >= DEPTH_LIM) begin
            fmt_err = ST_TOO_DEEP;
          end else begin
            flush_held();
            push_char(b);
            fmt_depth++;
            if (fmt_depth > deepest) deepest = fmt_depth;
            fmt_held = HELD_LINE;
            fmt_empty = 1'b1;
          end
        end else if (b == CH_RBRACE || b == CH_RBRACK) begin
          if (fmt_depth == 0) begin
            fmt_err = ST_UNMATCHED;
          end else begin
            fmt_depth--;
            if (fmt_empty) begin
              fmt_held = HELD_NONE;
            end else begin
              flush_held();
              push_line();
            end
            push_char(b);
            fmt_empty = 1'b0;
          end
        end else if (b == CH_COMMA) begin
          fmt_held = HELD_NONE;
          push_char(b);
          push_line();
          fmt_empty = 1'b0;
        end else if (b == CH_COLON) begin
          push_char(b);
          fmt_held = HELD_SPACE;
        end else begin
          flush_held();
          push_char(b);
          if (b == CH_QUOTE) fmt_in_str = 1'b1;
          fmt_empty = 1'b0;
        end
      end
    end
    if (l) begin
      if (fmt_err == ST_OK) begin
        if (!fmt_started) fmt_err = ST_NOT_JSON;
        else if (fmt_in_str) fmt_err = ST_OPEN_STR;
        else if (fmt_depth != 0) fmt_err = ST_OPEN_CONT;
        else flush_held();
      end
      // a row with a typed status sets the expectation directly
      if (typed_en) fmt_err = typed_st;
      stat_item = '{ch: CH_NUL, bv: 1'b0, last: 1'b1, st: fmt_err};
      pending_out.insert(pending_out.size(), stat_item);
      fmt_reset();
      texts_done++;
    end
  endtask

  // Offer one item, hold it until taken, then idle for a gap at the end of a burst.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (in_stall);
    format_byte(b, l);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 20);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic l, input int rep,
                         input logic typed, input status_t st);
    row_t r;
    r.b = b;
    r.last = l;
    r.rep = rep;
    r.typed = typed;
    r.st = st;
    stim_rows.insert(stim_rows.size(), r);
  endtask

  task automatic push_ws();
    int i;
    if ($urandom_range(0, 2) == 0) begin
      for (i = 0; i < $urandom_range(1, 2); i++) begin
        case ($urandom_range(0, 3))
          0: put_text(CH_SPACE);
          1: put_text(CH_TAB);
          2: put_text(CH_CR);
          default: put_text(CH_NL);
        endcase
      end
    end
  endtask

  task automatic push_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_text(s[i]);
  endtask

  task automatic gen_string();
    int i;
    int len;
    logic [7:0] c;
    len = $urandom_range(0, 5);
    put_text(CH_QUOTE);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        put_text(CH_BSLASH);
        put_text(8'($urandom_range(0, 255)));
      end else begin
        c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
        put_text(c);
      end
    end
    put_text(CH_QUOTE);
  endtask

  task automatic gen_scalar();
    int i;
    case ($urandom_range(0, 3))
      0, 1: gen_string();
      2: begin
        if ($urandom_range(0, 1) == 0) put_text("-");
        for (i = 0; i < $urandom_range(1, 4); i++)
          put_text(8'h30 + 8'($urandom_range(0, 9)));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: push_str("true");
          1: push_str("false");
          default: push_str("null");
        endcase
      end
    endcase
  endtask

  task automatic gen_container(input int lvl, input int maxlvl);
    int obj;
    int n;
    int i;
    obj = $urandom_range(0, 1);
    put_text(obj ? CH_LBRACE : CH_LBRACK);
    push_ws();
    if (chain_mode) n = (lvl == 0) ? $urandom_range(1, 2) : 1;
    else n = (lvl < 2) ? $urandom_range(0, 3) : $urandom_range(0, 1);
    for (i = 0; i < n; i++) begin
      if (i > 0) begin
        put_text(CH_COMMA);
        push_ws();
      end
      if (obj) begin
        gen_string();
        push_ws();
        put_text(CH_COLON);
        push_ws();
      end
      gen_value(lvl + 1, maxlvl);
      push_ws();
    end
    // close with the other bracket kind now and then
    if ($urandom_range(0, 9) == 0) obj = !obj;
    put_text(obj ? CH_RBRACE : CH_RBRACK);
  endtask

  task automatic gen_value(input int lvl, input int maxlvl);
    if (lvl < maxlvl && (chain_mode || $urandom_range(0, 2) == 0)) gen_container(lvl, maxlvl);
    else gen_scalar();
  endtask

  task automatic gen_text();
    int kind;
    int maxlvl;
    int i;
    int len;
    string noise;
    noise = "{}[],:\"\\ \ta1";
    text_q.delete();
    kind = $urandom_range(0, 9);
    chain_mode = 0;
    maxlvl = 3;
    if ($urandom_range(0, 7) == 0) begin
      chain_mode = 1;
      maxlvl = $urandom_range(DEPTH_LIM - 1, DEPTH_LIM + 1);
    end
    if (kind < 9) begin
      push_ws();
      gen_container(0, maxlvl);
      push_ws();
    end
    case (kind)
      6: begin
        // cut short, which mostly leaves an open string or open container
        if (text_q.size() > 1)
          text_q = text_q[0:$urandom_range(0, text_q.size() - 2)];
      end
      7: begin
        case ($urandom_range(0, 3))
          0: put_text(CH_RBRACK);
          1: push_str("12");
          2: put_text(CH_COLON);
          default: push_str("{}");
        endcase
      end
      8: begin
        if (text_q.size() > 1)
          text_q.insert($urandom_range(1, text_q.size() - 1),
                        ($urandom_range(0, 1) == 0) ? CH_COMMA : CH_COLON);
      end
      9: begin
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 1) == 0) put_text(noise[$urandom_range(0, noise.len() - 1)]);
          else put_text(8'($urandom_range(0, 255)));
        end
      end
      default: ;
    endcase
  endtask

  // receiver: stall pattern by segments, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_mode <= $urandom_range(0, 3);
        seg_left <= $urandom_range(10, 80);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (seg_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // compare each taken result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = '{ch: out_byte, bv: byte_valid, last: out_last, st: status};
      if (pending_out.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected item %0d: byte %02h valid %b last %b status %0d",
                   results_seen, got.ch, got.bv, got.last, got.st);
      end else begin
        want = pending_out.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch at item %0d: expected %02h/%b/%b/%0d, got %02h/%b/%b/%0d",
                     results_seen, want.ch, want.bv, want.last, want.st,
                     got.ch, got.bv, got.last, got.st);
        end
      end
      if (out_last) status_seen[status] = 1'b1;
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    int i;
    bit hold_done;
    bit pause_done;
    hold_done = 0;
    pause_done = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // leading whitespace, empty container
    add_row(CH_SPACE, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_LBRACK, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_RBRACK, 1'b1, 1, 1'b1, ST_OK);
    // first visible byte not a bracket
    add_row(CH_NUL, 1'b1, 1, 1'b1, ST_NOT_JSON);
    // escaped quote and top byte in a string, colon then comma, mixed kinds, text after close
    add_row(CH_LBRACE, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_QUOTE, 1'b0, 1, 1'b0, ST_OK);
    add_row(8'hff, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_BSLASH, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_QUOTE, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_QUOTE, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_COLON, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_COMMA, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_RBRACK, 1'b0, 1, 1'b0, ST_OK);
    add_row("1", 1'b1, 1, 1'b0, ST_OK);
    // comma after open bracket, unmatched close, later byte suppressed
    add_row(CH_LBRACK, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_COMMA, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_RBRACK, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_RBRACK, 1'b0, 1, 1'b0, ST_OK);
    add_row("x", 1'b1, 1, 1'b1, ST_UNMATCHED);
    // open string, open container
    add_row(CH_LBRACK, 1'b0, 1, 1'b0, ST_OK);
    add_row(CH_QUOTE, 1'b1, 1, 1'b1, ST_OPEN_STR);
    add_row(CH_LBRACE, 1'b1, 1, 1'b1, ST_OPEN_CONT);
    // full depth, then one more
    add_row(CH_LBRACK, 1'b0, DEPTH_LIM, 1'b0, ST_OK);
    add_row(CH_LBRACK, 1'b1, 1, 1'b1, ST_TOO_DEEP);

    foreach (stim_rows[k]) begin
      typed_en = stim_rows[k].typed;
      typed_st = stim_rows[k].st;
      for (r = 0; r < stim_rows[k].rep; r++)
        send_byte(stim_rows[k].b, stim_rows[k].last && (r == stim_rows[k].rep - 1));
      typed_en = 1'b0;
    end
    drain();

    while (rand_items < RAND_ITEMS) begin
      gen_text();
      for (i = 0; i < text_q.size(); i++) begin
        send_byte(text_q[i], i == text_q.size() - 1);
        rand_items++;
        if (!hold_done && rand_items >= 80) begin
          // long hold-off at the receiver while items keep coming
          hold_done = 1;
          hold_req <= hold_req + 1;
        end
      end
      if (!pause_done && rand_items >= 200) begin
        pause_done = 1;
        drain();
        @(posedge clk);
      end
    end
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d texts, %0d input items, %0d result items, deepest nesting %0d",
             texts_done, items_sent, results_seen, deepest);
    $display("status codes seen %b, %0d mismatches", status_seen, fail_cnt);
    if (fail_cnt == 0 && pending_out.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/jpp_pkg.sv
rtl/core/jpp_front.sv
rtl/core/jpp_queue.sv
rtl/core/jpp_back.sv
rtl/core/json_pretty_printer_top.sv
bench/json_pretty_printer_top_tb.sv
